### design/pst_pkg.sv
// ----------------------------------------------------------------------------
// Phased session timer package
// Shared widths, codes and bundle types for the session timer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

	localparam int TIME_W      = 48;
	localparam int LEN_W       = 32;
	localparam int PHASE_SLOTS = 4;
	// Sum of up to four 32-bit lengths.
	localparam int SUM_W       = LEN_W + 2;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_START  = 2'd1,
		KIND_CANCEL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_WAITING   = 2'd0,
		ST_COUNTDOWN = 2'd1,
		ST_PLAYING   = 2'd2,
		ST_RESULT    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_PLAY      = 3'd1,
		EV_ENDED     = 3'd2,
		EV_PHASE     = 3'd3,
		EV_COUNTDOWN = 3'd4,
		EV_REFUSED   = 3'd5
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNTDOWN = 3'd0,
		REG_PHASE_1   = 3'd1,
		REG_PHASE_2   = 3'd2,
		REG_PHASE_3   = 3'd3,
		REG_PHASE_4   = 3'd4
	} cfg_reg_t;

	typedef logic [PHASE_SLOTS-1:0][SUM_W-1:0] prefix_arr_t;

	typedef struct packed {
		logic [LEN_W-1:0] countdown_len;
		prefix_arr_t      prefix;
	} cfg_view_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] now_time;
	} item_t;

	typedef struct packed {
		event_t     ev;
		mode_t      st;
		logic [2:0] phase;
	} result_t;

endpackage

`default_nettype wire

### design/pst_cfg.sv
// ----------------------------------------------------------------------------
// Session timer configuration registers
// Holds the countdown and phase lengths and the registered running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_cfg #(
	parameter int PHASE_COUNT = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [pst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pst_pkg::LEN_W-1:0]      cfg_data,
	output pst_pkg::cfg_view_t                  view
);
	import pst_pkg::*;

	logic [LEN_W-1:0]                    cd_len_q;
	logic [PHASE_SLOTS-1:0][LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]                    cd_len_n;
	logic [PHASE_SLOTS-1:0][LEN_W-1:0]   len_n;
	prefix_arr_t                         prefix_n;
	prefix_arr_t                         prefix_q;
	logic [SUM_W-1:0]                    acc;

	always_comb begin
		cd_len_n = cd_len_q;
		len_n    = len_q;
		if (cfg_write) begin
			unique case (cfg_index)
				REG_COUNTDOWN: cd_len_n = cfg_data;
				REG_PHASE_1:   len_n[0] = cfg_data;
				REG_PHASE_2:   len_n[1] = cfg_data;
				REG_PHASE_3:   len_n[2] = cfg_data;
				REG_PHASE_4:   len_n[3] = cfg_data;
				default: ;
			endcase
		end
	end

	// Running sums are built from the values after this edge's write, so the
	// registered sums always agree with the registered lengths.
	always_comb begin
		acc = '0;
		for (int j = 0; j < PHASE_SLOTS; j++) begin
			if (j < PHASE_COUNT) begin
				acc = acc + SUM_W'(len_n[j]);
			end
			prefix_n[j] = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_len_q <= '0;
			len_q    <= '0;
			prefix_q <= '0;
		end else begin
			cd_len_q <= cd_len_n;
			len_q    <= len_n;
			prefix_q <= prefix_n;
		end
	end

	assign view.countdown_len = cd_len_q;
	assign view.prefix        = prefix_q;

endmodule

`default_nettype wire

### design/pst_engine.sv
// ----------------------------------------------------------------------------
// Session timer engine
// Session state and the single-pass next-state and event logic.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_engine #(
	parameter int PHASE_COUNT = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire pst_pkg::item_t     item,
	input  wire pst_pkg::cfg_view_t view,
	output pst_pkg::result_t        res
);
	import pst_pkg::*;

	localparam logic [2:0] LAST_PHASE = 3'(PHASE_COUNT);

	mode_t             mode_q, mode_n;
	logic [TIME_W-1:0] deadline_q, deadline_n;
	logic [TIME_W-1:0] start_q, start_n;
	logic [TIME_W-1:0] end_q, end_n;
	logic [2:0]        phase_q, phase_n;
	event_t            ev;

	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] base;
	logic [TIME_W-1:0] elapsed;
	logic [2:0]        phase_calc;
	logic              found;
	logic [TIME_W:0]   end_sum;
	logic [TIME_W:0]   dl_sum;
	logic [SUM_W-1:0]  total;

	assign now   = item.now_time;
	assign total = view.prefix[PHASE_SLOTS-1];
	// Play starts at the deadline, so phases are measured from it when the
	// countdown ends and from the stored start during play.
	assign base    = (mode_q == ST_COUNTDOWN) ? deadline_q : start_q;
	assign elapsed = now - base;
	assign end_sum = {1'b0, deadline_q} + (TIME_W+1)'(total);
	assign dl_sum  = {1'b0, now} + (TIME_W+1)'(view.countdown_len);

	always_comb begin
		phase_calc = LAST_PHASE;
		found      = 1'b0;
		if (now <= base) begin
			phase_calc = 3'd1;
		end else begin
			for (int i = 0; i < PHASE_SLOTS; i++) begin
				if (i < PHASE_COUNT && !found && elapsed < TIME_W'(view.prefix[i])) begin
					found      = 1'b1;
					phase_calc = 3'(i + 1);
				end
			end
		end
	end

	always_comb begin
		mode_n     = mode_q;
		deadline_n = deadline_q;
		start_n    = start_q;
		end_n      = end_q;
		phase_n    = phase_q;
		ev         = EV_NONE;
		case (item.kind)
			KIND_TICK: begin
				unique case (mode_q)
					ST_COUNTDOWN: begin
						if (now >= deadline_q) begin
							start_n = deadline_q;
							if (end_sum[TIME_W]) begin
								mode_n = ST_RESULT;
								ev     = EV_ENDED;
							end else begin
								end_n = end_sum[TIME_W-1:0];
								if (now >= end_sum[TIME_W-1:0]) begin
									mode_n  = ST_RESULT;
									phase_n = LAST_PHASE;
									ev      = EV_ENDED;
								end else begin
									mode_n  = ST_PLAYING;
									phase_n = phase_calc;
									ev      = EV_PLAY;
								end
							end
						end
					end
					ST_PLAYING: begin
						if (now >= end_q) begin
							mode_n = ST_RESULT;
							ev     = EV_ENDED;
						end else if (phase_calc != phase_q) begin
							phase_n = phase_calc;
							ev      = EV_PHASE;
						end
					end
					default: ;
				endcase
			end
			KIND_START: begin
				if (mode_q != ST_WAITING || dl_sum[TIME_W]) begin
					ev = EV_REFUSED;
				end else begin
					mode_n     = ST_COUNTDOWN;
					deadline_n = dl_sum[TIME_W-1:0];
					ev         = EV_COUNTDOWN;
				end
			end
			KIND_CANCEL: begin
				if (mode_q == ST_COUNTDOWN) begin
					mode_n     = ST_WAITING;
					deadline_n = '0;
					start_n    = '0;
					end_n      = '0;
					phase_n    = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= ST_WAITING;
			deadline_q <= '0;
			start_q    <= '0;
			end_q      <= '0;
			phase_q    <= '0;
		end else if (step) begin
			mode_q     <= mode_n;
			deadline_q <= deadline_n;
			start_q    <= start_n;
			end_q      <= end_n;
			phase_q    <= phase_n;
		end
	end

	assign res.ev    = ev;
	assign res.st    = mode_n;
	assign res.phase = phase_n;

endmodule

`default_nettype wire

### design/phased_session_timer_top.sv
// ----------------------------------------------------------------------------
// Phased session timer
// Runs a session through waiting, countdown, playing and result, reporting
// one event beat for every command beat.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  -------------------------------
//  in        input      in_valid / in_stall   kind, now_time
//  out       output     out_valid / out_stall event_code, session_state,
//                                             phase_number
//  cfg       input      cfg_write             cfg_index, cfg_data
//
// A command beat is accepted into the input register and, when it advances,
// passes through the engine into the result register, where its result beat
// is offered.
// A new command beat is taken every cycle while the output does not stall;
// the engine state updates once per beat.
// Reset clears the session state, the configuration registers and both
// valid flags. A stall on the output holds the result register and, once the
// input register is also full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module phased_session_timer_top #(
	parameter int PHASE_COUNT = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [1:0]                    kind,
	input  wire logic [pst_pkg::TIME_W-1:0]    now_time,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [2:0]                    event_code,
	output      logic [1:0]                    session_state,
	output      logic [2:0]                    phase_number,
	input  wire logic                          cfg_write,
	input  wire logic [pst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pst_pkg::LEN_W-1:0]     cfg_data
);
	import pst_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic      out_valid_q;
	result_t   res_q;
	result_t   res;
	cfg_view_t view;
	logic      advance;
	logic      accept;

	// The beat in the input register moves on when the result register is
	// empty or its beat is being taken in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	pst_cfg #(
		.PHASE_COUNT(PHASE_COUNT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.view      (view)
	);

	pst_engine #(
		.PHASE_COUNT(PHASE_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.view   (view),
		.res    (res)
	);

	// Valid flags carry reset; the payload registers load only when their
	// valid flag is being set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind     <= kind;
			item_s1.now_time <= now_time;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_code    = res_q.ev;
	assign session_state = res_q.st;
	assign phase_number  = res_q.phase;

endmodule

`default_nettype wire

### design/pst_checker.sv
// ----------------------------------------------------------------------------
// Session timer port checker
// Checks result beats at the top-level ports against the session rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] event_code,
	input wire logic [1:0] session_state,
	input wire logic [2:0] phase_number
);
	import pst_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code)
			&& $stable(session_state) && $stable(phase_number))
		else $error("result beat changed while stalled");

	// Once a beat reports the result state, every later beat does too.
	a_result_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && session_state == ST_RESULT |=> !out_valid || session_state == ST_RESULT)
		else $error("session left the result state");

	// Play starting always leaves the session in play.
	a_play_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_PLAY |-> session_state == ST_PLAYING)
		else $error("play started event outside the playing state");

	// A countdown begins from a cleared session.
	a_countdown_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_code == EV_COUNTDOWN |-> session_state == ST_COUNTDOWN
			&& phase_number == 3'd0)
		else $error("countdown started with a stale phase or state");

	// While waiting, no phase is active and only refusals or quiet beats occur.
	a_waiting_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && session_state == ST_WAITING |-> phase_number == 3'd0
			&& (event_code == EV_NONE || event_code == EV_REFUSED))
		else $error("unexpected event or phase while waiting");

endmodule

bind phased_session_timer_top pst_checker u_pst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.event_code    (event_code),
	.session_state (session_state),
	.phase_number  (phase_number)
);

`default_nettype wire
